### rtl/core/afc_pkg.sv
// Shared types, constants and character helpers for the AT line framer.
package afc_pkg;

    localparam int LINE_CAP   = 256;
    localparam int LEN_W      = 9;
    localparam int KIND_W     = 3;
    localparam int OVF_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int LEN_OK     = 2;
    localparam int LEN_ERROR  = 5;
    localparam int PREFIX_LEN = 11;
    localparam int TEXT_W     = PREFIX_LEN * BYTE_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);
    localparam logic [BYTE_W-1:0]  FOLD_OFFSET = BYTE_W'(32);
    localparam logic [BYTE_W-1:0]  CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0]  CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0]  CHAR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0]  CHAR_SPACE  = 8'h20;

    // Words are left-justified in an 11-character field, first character on top.
    localparam logic [TEXT_W-1:0] TEXT_OK    = {"OK", 72'h0};
    localparam logic [TEXT_W-1:0] TEXT_ERROR = {"ERROR", 48'h0};
    localparam logic [TEXT_W-1:0] TEXT_CME   = "+CME ERROR:";
    localparam logic [TEXT_W-1:0] TEXT_CMS   = "+CMS ERROR:";

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [MODE_W-1:0] {
        TERM_CRLF = 2'd0,
        TERM_CR   = 2'd1,
        TERM_LF   = 2'd2,
        TERM_BOTH = 2'd3
    } term_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TERM_MODE  = 2'd0,
        CFG_CASE_FOLD  = 2'd1,
        CFG_LINE_LIMIT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER = 3'd0,
        KIND_OK    = 3'd1,
        KIND_ERROR = 3'd2,
        KIND_CME   = 3'd3,
        KIND_CMS   = 3'd4
    } line_kind_t;

    // Packed with line_length in the lowest bits.
    typedef struct packed {
        logic [OVF_W-1:0]  overflow_total;
        line_kind_t        line_kind;
        logic [LEN_W-1:0]  line_length;
    } result_t;

    localparam int RES_W        = $bits(result_t);
    localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

    function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c inside {["A":"Z"]})
        begin
            r = c + FOLD_OFFSET;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] text_char(input logic [TEXT_W-1:0] text,
                                                   input logic [3:0] pos);
        logic [BYTE_W-1:0] r;
        r = '0;
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            if (pos == 4'(i))
            begin
                r = text[TEXT_W-1-BYTE_W*i -: BYTE_W];
            end
        end
        return r;
    endfunction

    function automatic logic same_char(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] b,
                                       input logic fold);
        logic r;
        if (fold)
        begin
            r = (fold_char(a) == fold_char(b));
        end
        else
        begin
            r = (a == b);
        end
        return r;
    endfunction

endpackage

### rtl/core/afc_fifo.sv
// Short result queue between the framer front end and the output stage.
module afc_fifo
    import afc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output result_t pop_data,
    output logic    full,
    output logic    not_empty
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("result pushed into a full queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count past depth");

endmodule

### rtl/core/afc_front.sv
// Front end: config registers, line framing, running word match and classification.
module afc_front
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  queue_full,
    output logic                  push,
    output result_t               push_data
);

    term_mode_t           term_mode_reg;
    logic                 case_fold_reg;
    logic [LIMIT_W-1:0]   line_limit_reg;

    logic [LEN_W-1:0]     length_reg, length_next;
    logic                 drop_reg, drop_next;
    logic                 cr_seen_reg, cr_seen_next;
    logic [3:0]           match_reg, match_next;
    logic [1:0]           suffix_reg, suffix_next;
    logic [OVF_W-1:0]     ovf_reg, ovf_next;

    logic                 accept;
    logic                 is_cr, is_lf;
    logic                 line_end, content;
    logic [LIMIT_W-1:0]   limit_eff;
    logic [3:0]           char_hit;
    logic [3:0]           kill;
    logic                 suffix_set;
    logic [3:0]           pos;
    line_kind_t           kind;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign is_cr     = (s_tdata == CHAR_CR);
    assign is_lf     = (s_tdata == CHAR_LF);
    assign pos       = length_reg[3:0];
    assign limit_eff = (line_limit_reg > LIMIT_W'(LINE_CAP)) ? LIMIT_W'(LINE_CAP)
                                                              : line_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_mode_reg  <= TERM_CRLF;
            case_fold_reg  <= 1'b0;
            line_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TERM_MODE:  term_mode_reg  <= term_mode_t'(cfg_data[MODE_W-1:0]);
                CFG_CASE_FOLD:  case_fold_reg  <= cfg_data[0];
                CFG_LINE_LIMIT: line_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Terminator decode.
    always_comb
    begin
        line_end     = 1'b0;
        content      = 1'b0;
        cr_seen_next = cr_seen_reg;
        if (term_mode_reg == TERM_CRLF)
        begin
            if (is_cr)
            begin
                cr_seen_next = 1'b1;
                line_end     = 1'b1;
            end
            else if (cr_seen_reg)
            begin
                // swallow the LF right after a CR
                cr_seen_next = 1'b0;
                content      = !is_lf;
            end
            else if (is_lf)
            begin
                line_end = 1'b1;
            end
            else
            begin
                content = 1'b1;
            end
        end
        else if (is_cr || is_lf)
        begin
            if (!((term_mode_reg == TERM_LF && is_cr) || (term_mode_reg == TERM_CR && is_lf)))
            begin
                line_end = 1'b1;
            end
        end
        else
        begin
            content = 1'b1;
        end
    end

    always_comb
    begin
        char_hit[0] = same_char(s_tdata, text_char(TEXT_OK, pos), case_fold_reg);
        char_hit[1] = same_char(s_tdata, text_char(TEXT_ERROR, pos), case_fold_reg);
        char_hit[2] = same_char(s_tdata, text_char(TEXT_CME, pos), case_fold_reg);
        char_hit[3] = same_char(s_tdata, text_char(TEXT_CMS, pos), case_fold_reg);
        kill[0] = (length_reg < LEN_W'(LEN_OK))     ? !char_hit[0] : 1'b1;
        kill[1] = (length_reg < LEN_W'(LEN_ERROR))  ? !char_hit[1] : 1'b1;
        kill[2] = (length_reg < LEN_W'(PREFIX_LEN)) ? !char_hit[2] : 1'b0;
        kill[3] = (length_reg < LEN_W'(PREFIX_LEN)) ? !char_hit[3] : 1'b0;
        suffix_set = (length_reg == LEN_W'(PREFIX_LEN))
                     && (s_tdata == CHAR_COLON || s_tdata == CHAR_SPACE);
    end

    always_comb
    begin
        kind = KIND_OTHER;
        if (match_reg[0] && length_reg == LEN_W'(LEN_OK))
        begin
            kind = KIND_OK;
        end
        else if (match_reg[1] && length_reg == LEN_W'(LEN_ERROR))
        begin
            kind = KIND_ERROR;
        end
        else if (match_reg[2] && (length_reg == LEN_W'(PREFIX_LEN)
                 || (length_reg > LEN_W'(PREFIX_LEN) && suffix_reg[0])))
        begin
            kind = KIND_CME;
        end
        else if (match_reg[3] && (length_reg == LEN_W'(PREFIX_LEN)
                 || (length_reg > LEN_W'(PREFIX_LEN) && suffix_reg[1])))
        begin
            kind = KIND_CMS;
        end
    end

    always_comb
    begin
        length_next = length_reg;
        drop_next   = drop_reg;
        match_next  = match_reg;
        suffix_next = suffix_reg;
        ovf_next    = ovf_reg;
        push        = 1'b0;
        push_data.overflow_total = ovf_reg;
        push_data.line_kind      = kind;
        push_data.line_length    = length_reg;
        if (accept && line_end)
        begin
            // report unless discarded, then start a fresh line
            push        = !drop_reg;
            drop_next   = 1'b0;
            length_next = '0;
            match_next  = '1;
            suffix_next = '0;
        end
        else if (accept && content && !drop_reg)
        begin
            if (length_reg >= limit_eff)
            begin
                drop_next   = 1'b1;
                ovf_next    = ovf_reg + 1'b1;
                length_next = '0;
            end
            else
            begin
                match_next     = match_reg & ~kill;
                suffix_next[0] = suffix_reg[0] | (match_reg[2] & suffix_set);
                suffix_next[1] = suffix_reg[1] | (match_reg[3] & suffix_set);
                length_next    = length_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= '0;
            drop_reg    <= 1'b0;
            cr_seen_reg <= 1'b0;
            match_reg   <= '1;
            suffix_reg  <= '0;
            ovf_reg     <= '0;
        end
        else
        begin
            length_reg  <= length_next;
            drop_reg    <= drop_next;
            match_reg   <= match_next;
            suffix_reg  <= suffix_next;
            ovf_reg     <= ovf_next;
            if (accept)
            begin
                cr_seen_reg <= cr_seen_next;
            end
        end
    end

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (length_reg == '0))
        else $error("discarded line still holds a length");
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(LINE_CAP))
        else $error("line length past capacity");

endmodule

### rtl/core/afc_back.sv
// Back end: output register that drains the result queue onto the master stream.
module afc_back
    import afc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   queue_not_empty,
    input  result_t                queue_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    // Refill whenever the register is empty or being taken this cycle.
    assign pop = queue_not_empty && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= queue_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-RES_W)'(0), out_data_reg};

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> queue_not_empty)
        else $error("pop from an empty queue");

endmodule

### rtl/core/at_line_framer_classifier.sv
// Top level of the AT line framer and final-result classifier.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] rx_byte
//  cfg_*     in   cfg_valid/ready    cfg_index (0 term_mode, 1 case_fold, 2 line_limit),
//                                    cfg_data
//  m_*       out  m_tvalid/m_tready  m_tdata: line_length, line_kind, overflow_total
//
// One byte is accepted per cycle while the queue is not full; the front end decodes and
// classifies it in that cycle and writes any line result into a four-entry queue.
// The edge that accepts a terminating byte pushes its result into the queue; the output
// register loads it from there and raises m_tvalid once the register is empty or being taken.
// s_tready drops only while the queue is full; the output register refills in the
// same cycle it is taken when the queue holds a result. cfg_ready is always high.
// Reset is asynchronous and active low and needs no clearing pass.
module at_line_framer_classifier
    import afc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [8:0] line_length, [11:9] line_kind,
                                              // [43:12] overflow_total, [47:44] zero
);

    logic    push, pop, queue_full, queue_not_empty;
    result_t push_data, queue_data;

    afc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    afc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (queue_data),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    afc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_data      (queue_data),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

### sim/at_line_framer_classifier_tb.sv
// Testbench for the AT line framer: byte stimulus, line prediction and result checks.
module at_line_framer_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import afc_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    at_line_framer_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 clk = ~clk;

    // Predicted block configuration and line state
    term_mode_t         cur_mode   = TERM_CRLF;
    logic               cur_fold   = 1'b0;
    logic [LIMIT_W-1:0] cur_limit  = LIMIT_RESET;
    logic [LEN_W-1:0]   run_len    = '0;
    logic               dropping   = 1'b0;
    logic               cr_pending = 1'b0;
    logic [3:0]         word_live  = 4'hF;
    logic [1:0]         sep_seen   = 2'b00;
    logic [OVF_W-1:0]   ovf_count  = '0;

    result_t            pending_lines[$];
    logic [BYTE_W-1:0]  line_bytes[$];
    int                 errors     = 0;
    bit                 no_gaps    = 1'b0;
    int                 rx_sent    = 0;
    int                 stall_left = 0;

    function automatic logic [BYTE_W-1:0] lower_letter(input logic [BYTE_W-1:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic chars_equal(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        if (cur_fold)
        begin
            return lower_letter(a) == lower_letter(b);
        end
        return a == b;
    endfunction

    function automatic string word_text(input int k);
        case (k)
            0:       return "OK";
            1:       return "ERROR";
            2:       return "+CME ERROR:";
            default: return "+CMS ERROR:";
        endcase
    endfunction

    function automatic line_kind_t kind_of_line();
        if (word_live[0] && run_len == LEN_W'(LEN_OK))
        begin
            return KIND_OK;
        end
        if (word_live[1] && run_len == LEN_W'(LEN_ERROR))
        begin
            return KIND_ERROR;
        end
        if (word_live[2] && (run_len == LEN_W'(PREFIX_LEN) ||
                             (run_len > LEN_W'(PREFIX_LEN) && sep_seen[0])))
        begin
            return KIND_CME;
        end
        if (word_live[3] && (run_len == LEN_W'(PREFIX_LEN) ||
                             (run_len > LEN_W'(PREFIX_LEN) && sep_seen[1])))
        begin
            return KIND_CMS;
        end
        return KIND_OTHER;
    endfunction

    task automatic close_line();
        result_t r;
        if (dropping)
        begin
            dropping = 1'b0;
        end
        else
        begin
            r.line_length    = run_len;
            r.line_kind      = kind_of_line();
            r.overflow_total = ovf_count;
            pending_lines.push_back(r);
        end
        run_len   = '0;
        word_live = 4'hF;
        sep_seen  = 2'b00;
    endtask

    // Advance the predicted framer by one accepted byte
    task automatic frame_byte(input logic [BYTE_W-1:0] b);
        logic               is_cr;
        logic               is_lf;
        logic [LIMIT_W-1:0] lim;
        string              w;
        is_cr = (b == CHAR_CR);
        is_lf = (b == CHAR_LF);
        if (cur_mode == TERM_CRLF)
        begin
            if (is_cr)
            begin
                cr_pending = 1'b1;
                close_line();
                return;
            end
            if (cr_pending)
            begin
                cr_pending = 1'b0;
                if (is_lf)
                begin
                    return;
                end
            end
            else if (is_lf)
            begin
                close_line();
                return;
            end
        end
        else if (is_cr || is_lf)
        begin
            if ((cur_mode == TERM_LF && is_cr) || (cur_mode == TERM_CR && is_lf))
            begin
                return;
            end
            close_line();
            return;
        end

        if (dropping)
        begin
            return;
        end
        lim = (cur_limit > LIMIT_W'(LINE_CAP)) ? LIMIT_W'(LINE_CAP) : cur_limit;
        if (run_len >= lim)
        begin
            dropping  = 1'b1;
            ovf_count = ovf_count + 1;
            run_len   = '0;
            return;
        end
        for (int k = 0; k < 4; k++)
        begin
            w = word_text(k);
            if (word_live[k])
            begin
                if (run_len < w.len())
                begin
                    if (!chars_equal(b, w[run_len]))
                    begin
                        word_live[k] = 1'b0;
                    end
                end
                else if (k < 2)
                begin
                    word_live[k] = 1'b0;
                end
                else if (run_len == w.len() && (b == CHAR_COLON || b == CHAR_SPACE))
                begin
                    sep_seen[k-2] = 1'b1;
                end
            end
        end
        run_len = run_len + 1'b1;
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // Send one byte request, keep tvalid high for a back-to-back follow-up
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!no_gaps && $urandom_range(0, 11) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        frame_byte(b);
        rx_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_filler(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_byte("a" + 8'(i % 26));
        end
    endtask

    // Hold the sender until every predicted line has come out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TERM_MODE:  cur_mode  = term_mode_t'(val[MODE_W-1:0]);
            CFG_CASE_FOLD:  cur_fold  = val[0];
            CFG_LINE_LIMIT: cur_limit = val;
            default:        ;
        endcase
    endtask

    // Receiver: random stall bursts, no new burst starts while no_gaps is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!no_gaps && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_W-1:0];
            if (pending_lines.size() == 0)
            begin
                report_mismatch("unexpected line, length", -1, got.line_length);
            end
            else
            begin
                want = pending_lines.pop_front();
                if (got.line_length !== want.line_length)
                begin
                    report_mismatch("line_length", want.line_length, got.line_length);
                end
                if (got.line_kind !== want.line_kind)
                begin
                    report_mismatch("line_kind", want.line_kind, got.line_kind);
                end
                if (got.overflow_total !== want.overflow_total)
                begin
                    report_mismatch("overflow_total", want.overflow_total, got.overflow_total);
                end
            end
        end
    end

    task automatic test_default_words();
        send_line("OK");
        send_line("ERROR");
        send_line("");
        send_line("+CME ERROR: 10");
        send_line("+CMS ERROR:");
        send_line("ok");
        send_line("+CME ERROR");
        send_line("+CMS ERROR:x");
        send_line("OKAY");
        // bare LF ends a line too
        send_text("ERROR");
        send_byte(CHAR_LF);
        // CR followed by a non-LF byte: that byte starts the next line
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_text("OK");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic test_case_fold();
        write_reg(CFG_CASE_FOLD, 9'd1);
        send_line("ok");
        send_line("eRRor");
        send_line("+cme error:5");
        send_line("+cMs Error: x");
        send_line("o@");
        write_reg(CFG_CASE_FOLD, 9'd0);
        send_line("Ok");
    endtask

    task automatic test_term_modes();
        write_reg(CFG_TERM_MODE, 9'(TERM_CR));
        send_text("OK");
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_text("ER");
        send_byte(CHAR_LF);
        send_text("ROR");
        send_byte(CHAR_CR);
        write_reg(CFG_TERM_MODE, 9'(TERM_LF));
        send_text("OK");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        write_reg(CFG_TERM_MODE, 9'(TERM_BOTH));
        send_text("OK");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // CR left pending in CR-LF mode survives a detour through LF mode
        write_reg(CFG_TERM_MODE, 9'(TERM_CRLF));
        send_text("A");
        send_byte(CHAR_CR);
        write_reg(CFG_TERM_MODE, 9'(TERM_LF));
        send_text("B");
        send_byte(CHAR_LF);
        write_reg(CFG_TERM_MODE, 9'(TERM_CRLF));
        send_byte(CHAR_LF);
        send_line("OK");
    endtask

    task automatic test_line_limits();
        write_reg(CFG_LINE_LIMIT, 9'd8);
        send_line("12345678");
        send_line("123456789ABC");
        send_line("");
        write_reg(CFG_LINE_LIMIT, 9'd0);
        send_line("X");
        send_line("");
        write_reg(CFG_LINE_LIMIT, 9'd5);
        send_line("ERROR");
        send_line("ERRORS");
        write_reg(CFG_LINE_LIMIT, 9'd300);
        send_filler(256);
        send_byte(CHAR_CR);
        send_filler(257);
        send_byte(CHAR_LF);
        write_reg(CFG_LINE_LIMIT, 9'd256);
        send_text("+CME ERROR: ");
        send_filler(244);
        send_byte(CHAR_CR);
        write_reg(CFG_UNUSED, 9'h1FF);
        send_line("OK");
        write_reg(CFG_LINE_LIMIT, 9'd511);
        send_line("ERROR");
        write_reg(CFG_LINE_LIMIT, LIMIT_RESET);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_terminator();
        int pick;
        pick = $urandom_range(0, 9);
        case (cur_mode)
            TERM_CRLF:
            begin
                if (pick < 7)
                begin
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
                else if (pick < 9)
                begin
                    send_byte(CHAR_CR);
                end
                else
                begin
                    send_byte(CHAR_LF);
                end
            end
            TERM_CR:  send_byte(CHAR_CR);
            TERM_LF:  send_byte(CHAR_LF);
            default:  send_byte(pick[0] ? CHAR_CR : CHAR_LF);
        endcase
    endtask

    // Build and send one line: result words, broken or split words, noise, empty and long lines
    task automatic send_random_line();
        int                 pick;
        int                 n;
        int                 lim;
        string              w;
        logic [BYTE_W-1:0]  c;
        line_bytes.delete();
        lim  = (cur_limit > LINE_CAP) ? LINE_CAP : int'(cur_limit);
        pick = $urandom_range(0, 9);
        case (pick)
            0: push_text("OK");
            1: push_text("ERROR");
            2, 3:
            begin
                push_text(pick == 2 ? "+CME ERROR:" : "+CMS ERROR:");
                case ($urandom_range(0, 3))
                    0: line_bytes.push_back(CHAR_SPACE);
                    1: line_bytes.push_back(CHAR_COLON);
                    2: line_bytes.push_back("5");
                    default: ;
                endcase
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    line_bytes.push_back("0" + 8'($urandom_range(0, 9)));
                end
            end
            4:
            begin
                // broken word: one byte dropped or replaced
                push_text(word_text($urandom_range(0, 3)));
                n = $urandom_range(0, line_bytes.size() - 1);
                if ($urandom_range(0, 1))
                begin
                    line_bytes.delete(n);
                end
                else
                begin
                    line_bytes[n] = 8'($urandom_range(32, 126));
                end
            end
            5:
            begin
                n = $urandom_range(0, 20);
                for (int i = 0; i < n; i++)
                begin
                    line_bytes.push_back(8'($urandom_range(32, 126)));
                end
            end
            6:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    line_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            7: ;
            8:
            begin
                n = $urandom_range((lim > 0) ? lim - 1 : 0, lim + 2);
                for (int i = 0; i < n; i++)
                begin
                    line_bytes.push_back(8'($urandom_range(32, 126)));
                end
            end
            default:
            begin
                // in CR or LF mode, word split by a byte that mode ignores
                w = word_text($urandom_range(0, 1));
                push_text(w.substr(0, 0));
                if (cur_mode == TERM_CR)
                begin
                    line_bytes.push_back(CHAR_LF);
                end
                else if (cur_mode == TERM_LF)
                begin
                    line_bytes.push_back(CHAR_CR);
                end
                push_text(w.substr(1, w.len() - 1));
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            foreach (line_bytes[i])
            begin
                c = line_bytes[i];
                if ($urandom_range(0, 1) && lower_letter(c) != c)
                begin
                    line_bytes[i] = lower_letter(c);
                end
            end
        end
        foreach (line_bytes[i])
        begin
            send_byte(line_bytes[i]);
        end
        send_terminator();
    endtask

    task automatic test_random_traffic();
        int start;
        int phase_start;
        int lim_pick;
        logic [LIMIT_W-1:0] lim;
        bit paused;
        start = rx_sent;
        while (rx_sent - start < 850)
        begin
            no_gaps = (rx_sent - start >= 700) ? 1'b1 : ($urandom_range(0, 4) == 0);
            write_reg(CFG_TERM_MODE, 9'($urandom_range(0, 2)));
            write_reg(CFG_CASE_FOLD, 9'($urandom_range(0, 1)));
            lim_pick = $urandom_range(0, 5);
            case (lim_pick)
                0:       lim = 9'd8;
                1:       lim = 9'($urandom_range(8, 24));
                2:       lim = LIMIT_RESET;
                3:       lim = 9'd256;
                4:       lim = 9'($urandom_range(0, 511));
                default: lim = 9'($urandom_range(8, 16));
            endcase
            write_reg(CFG_LINE_LIMIT, lim);
            phase_start = rx_sent;
            paused = 1'b0;
            while (rx_sent - phase_start < 150)
            begin
                if (!paused && rx_sent - phase_start >= 75)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_random_line();
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_words();
        test_case_fold();
        test_term_modes();
        test_line_limits();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("** at_line_framer_classifier: PASSED **");
        end
        else
        begin
            $display("** at_line_framer_classifier: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("** at_line_framer_classifier: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/core/afc_pkg.sv
rtl/core/afc_fifo.sv
rtl/core/afc_front.sv
rtl/core/afc_back.sv
rtl/core/at_line_framer_classifier.sv
sim/at_line_framer_classifier_tb.sv
